// ----- rtl/glot_pkg.sv -----
// Shared constants, codes and controller/datapath command types for the
// grid layer offset table. No dependencies.
package glot_pkg;

    localparam int MAX_CELLS  = 4096;
    localparam int COUNT_BITS = 10;
    localparam int ADDR_BITS  = $clog2(MAX_CELLS);
    localparam int PTR_BITS   = $clog2(MAX_CELLS + 1);
    localparam int REG_BITS   = 13;
    localparam int SUM_BITS   = 22;
    localparam int LON_BITS   = 12;
    localparam int LAT_BITS   = 12;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GRID_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_GRID_HEIGHT = t_cfg_idx'(1);

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic capture;
        logic calc;
        logic read;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
    } t_dp_stat;

endpackage

// ----- rtl/glot_item_if.sv -----
// Input channel of the grid layer offset table: valid/ready and item fields.
// Depends on glot_pkg.
interface glot_item_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic                           first_cell;
    logic [glot_pkg::COUNT_BITS-1:0] cell_layers;
    logic [glot_pkg::LON_BITS-1:0]  lon_index;
    logic [glot_pkg::LAT_BITS-1:0]  lat_index;

    modport source (
        output valid, mode, first_cell, cell_layers, lon_index, lat_index,
        input  ready
    );
    modport sink (
        input  valid, mode, first_cell, cell_layers, lon_index, lat_index,
        output ready
    );
endinterface

// ----- rtl/glot_result_if.sv -----
// Result channel of the grid layer offset table: valid/ready and result fields.
// Depends on glot_pkg.
interface glot_result_if;
    logic                           valid;
    logic                           ready;
    logic                           in_range;
    logic [glot_pkg::COUNT_BITS-1:0] layers_out;
    logic [glot_pkg::SUM_BITS-1:0]  start_out;
    logic [glot_pkg::SUM_BITS-1:0]  total_layers;
    logic [glot_pkg::COUNT_BITS-1:0] peak_layers;

    modport source (
        output valid, in_range, layers_out, start_out, total_layers, peak_layers,
        input  ready
    );
    modport sink (
        input  valid, in_range, layers_out, start_out, total_layers, peak_layers,
        output ready
    );
endinterface

// ----- rtl/glot_dpath.sv -----
// Datapath of the grid layer offset table: grid registers, item capture,
// address arithmetic, count/offset memory, running sums and result register.
// Depends on glot_pkg.
module glot_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  glot_pkg::t_dp_cmd               i_cmd,
    output glot_pkg::t_dp_stat              o_stat,
    input  logic                            i_cfg_we,
    input  glot_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [glot_pkg::REG_BITS-1:0]   i_cfg_data,
    input  logic                            i_mode,
    input  logic                            i_first_cell,
    input  logic [glot_pkg::COUNT_BITS-1:0] i_cell_layers,
    input  logic [glot_pkg::LON_BITS-1:0]   i_lon_index,
    input  logic [glot_pkg::LAT_BITS-1:0]   i_lat_index,
    output logic                            o_in_range,
    output logic [glot_pkg::COUNT_BITS-1:0] o_layers_out,
    output logic [glot_pkg::SUM_BITS-1:0]   o_start_out,
    output logic [glot_pkg::SUM_BITS-1:0]   o_total_layers,
    output logic [glot_pkg::COUNT_BITS-1:0] o_peak_layers
);

    localparam int ROT_BITS  = glot_pkg::REG_BITS + 1;
    localparam int PROD_BITS = glot_pkg::LAT_BITS + glot_pkg::REG_BITS;
    localparam int FULL_BITS = 2 * glot_pkg::REG_BITS;

    typedef struct packed {
        logic [glot_pkg::COUNT_BITS-1:0] count;
        logic [glot_pkg::SUM_BITS-1:0]   offset;
    } t_cell_entry;

    t_cell_entry mem [glot_pkg::MAX_CELLS];

    logic [glot_pkg::REG_BITS-1:0]   r_grid_width;
    logic [glot_pkg::REG_BITS-1:0]   r_grid_height;
    logic                            r_mode;
    logic                            r_first;
    logic [glot_pkg::COUNT_BITS-1:0] r_count;
    logic [glot_pkg::LON_BITS-1:0]   r_lon;
    logic [glot_pkg::LAT_BITS-1:0]   r_lat;
    logic [glot_pkg::SUM_BITS-1:0]   r_sum;
    logic [glot_pkg::COUNT_BITS-1:0] r_max;
    logic [glot_pkg::PTR_BITS-1:0]   r_ptr;
    logic                            r_hit;
    logic [glot_pkg::ADDR_BITS-1:0]  r_addr;
    t_cell_entry                     r_rd_data;
    logic                            r_in_range;
    logic [glot_pkg::COUNT_BITS-1:0] r_layers_out;
    logic [glot_pkg::SUM_BITS-1:0]   r_start_out;
    logic [glot_pkg::SUM_BITS-1:0]   r_total_out;
    logic [glot_pkg::COUNT_BITS-1:0] r_peak_out;

    logic [glot_pkg::SUM_BITS-1:0]   n_sum;
    logic [glot_pkg::COUNT_BITS-1:0] n_max;
    logic [glot_pkg::PTR_BITS-1:0]   n_ptr;

    logic [ROT_BITS-1:0]             rot_sum;
    logic [ROT_BITS-1:0]             rot;
    logic [PROD_BITS-1:0]            lat_prod;
    logic [FULL_BITS-1:0]            addr_full;
    logic                            q_hit;

    logic [glot_pkg::PTR_BITS-1:0]   ptr_eff;
    logic [glot_pkg::SUM_BITS-1:0]   sum_eff;
    logic [glot_pkg::COUNT_BITS-1:0] max_eff;
    logic [FULL_BITS-1:0]            cell_lim;
    logic                            can_store;
    logic [glot_pkg::SUM_BITS:0]     sum_wide;
    logic                            do_write;

    assign o_stat.is_query = (r_mode == glot_pkg::MODE_QUERY);

    // Query address: rotate longitude by half the width, then add the row base
    always_comb begin
        rot_sum   = ROT_BITS'(r_lon) + ROT_BITS'(r_grid_width >> 1);
        rot       = (rot_sum >= ROT_BITS'(r_grid_width)) ?
                    rot_sum - ROT_BITS'(r_grid_width) : rot_sum;
        lat_prod  = PROD_BITS'(r_lat) * PROD_BITS'(r_grid_width);
        addr_full = FULL_BITS'(rot) + FULL_BITS'(lat_prod);
        q_hit     = (glot_pkg::REG_BITS'(r_lon) < r_grid_width) &&
                    (glot_pkg::REG_BITS'(r_lat) < r_grid_height) &&
                    (addr_full < FULL_BITS'(glot_pkg::MAX_CELLS));
    end

    // Load: a first cell restarts the pointer and clears the running sum and peak count
    always_comb begin
        ptr_eff   = r_first ? '0 : r_ptr;
        sum_eff   = r_first ? '0 : r_sum;
        max_eff   = r_first ? '0 : r_max;
        cell_lim  = FULL_BITS'(r_grid_width) * FULL_BITS'(r_grid_height);
        can_store = (FULL_BITS'(ptr_eff) < cell_lim) &&
                    (ptr_eff < glot_pkg::PTR_BITS'(glot_pkg::MAX_CELLS));
        sum_wide  = (glot_pkg::SUM_BITS + 1)'(sum_eff) +
                    (glot_pkg::SUM_BITS + 1)'(r_count);
        do_write  = i_cmd.calc && (r_mode == glot_pkg::MODE_LOAD) && can_store;
        if (can_store) begin
            n_sum = sum_wide[glot_pkg::SUM_BITS] ? glot_pkg::SUM_MAX :
                    sum_wide[glot_pkg::SUM_BITS-1:0];
            n_max = (r_count > max_eff) ? r_count : max_eff;
            n_ptr = ptr_eff + glot_pkg::PTR_BITS'(1);
        end else begin
            n_sum = sum_eff;
            n_max = max_eff;
            n_ptr = ptr_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= glot_pkg::REG_BITS'(1);
            r_grid_height <= glot_pkg::REG_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                glot_pkg::CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                glot_pkg::CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_max <= '0;
            r_ptr <= '0;
        end else if (i_cmd.calc && (r_mode == glot_pkg::MODE_LOAD)) begin
            r_sum <= n_sum;
            r_max <= n_max;
            r_ptr <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_first <= i_first_cell;
            r_count <= i_cell_layers;
            r_lon   <= i_lon_index;
            r_lat   <= i_lat_index;
        end
        if (i_cmd.calc) begin
            r_hit  <= (r_mode == glot_pkg::MODE_QUERY) && q_hit;
            r_addr <= addr_full[glot_pkg::ADDR_BITS-1:0];
        end
        if (i_cmd.out_load) begin
            r_in_range   <= r_hit;
            r_layers_out <= r_hit ? r_rd_data.count  : '0;
            r_start_out  <= r_hit ? r_rd_data.offset : '0;
            r_total_out  <= r_sum;
            r_peak_out   <= r_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem[ptr_eff[glot_pkg::ADDR_BITS-1:0]] <= '{count: r_count, offset: sum_eff};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_data <= mem[r_addr];
        end
    end

    assign o_in_range     = r_in_range;
    assign o_layers_out   = r_layers_out;
    assign o_start_out    = r_start_out;
    assign o_total_layers = r_total_out;
    assign o_peak_layers  = r_peak_out;

endmodule

// ----- rtl/glot_ctrl.sv -----
// Controller of the grid layer offset table: sequences capture, calculation,
// memory read and result hand-off, and owns the result valid flag.
// Depends on glot_pkg.
module glot_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output glot_pkg::t_dp_cmd   o_cmd,
    input  glot_pkg::t_dp_stat  i_stat
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_READ = 4'b0100,
        ST_RESP = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CALC;
            end
            ST_CALC: begin
                n_state = i_stat.is_query ? ST_READ : ST_RESP;
            end
            ST_READ: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        o_cmd.capture  = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.calc     = (r_state == ST_CALC);
        o_cmd.read     = (r_state == ST_READ);
        o_cmd.out_load = (r_state == ST_RESP) && out_free;
        // hold the result until taken; a fresh load replaces it
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_CALC))
        else $error("accepted transaction did not move to calculation");

    a_read_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> i_stat.is_query)
        else $error("memory read issued for a load transaction");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("result hand-off did not raise valid and return to idle");

endmodule

// ----- rtl/grid_layer_offset_table_unit.sv -----
// Top level of the grid layer offset table: joins controller and datapath
// to the item and result channels. Depends on glot_pkg, glot_item_if,
// glot_result_if, glot_ctrl and glot_dpath.
//
// Load items (mode 0) store each cell's layer count with its exclusive
// running-sum start offset in a 4096-entry table and update the running
// total and peak count; a first-cell flag restarts at cell zero. Query items
// (mode 1) rotate the longitude by half the grid width, add lat * width and
// return that cell's count and offset, with in_range low when the cell lies
// outside the grid or the table. Items are handled one at a time: a load
// passes capture, address and sum calculation and result hand-off, and a
// query also a registered read of the table memory before the hand-off.
// The result register frees the input side, so the next item is taken
// while a result still waits. The table has no clearing pass; a query of
// a cell never loaded returns undefined count and offset. Write grid_width
// (index 0) and grid_height (index 1) only while the block is idle.
module grid_layer_offset_table_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  glot_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [glot_pkg::REG_BITS-1:0] i_cfg_data,
    glot_item_if.sink                     i_item,
    glot_result_if.source                 o_result
);

    glot_pkg::t_dp_cmd  dp_cmd;
    glot_pkg::t_dp_stat dp_stat;

    glot_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    glot_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_item.mode),
        .i_first_cell   (i_item.first_cell),
        .i_cell_layers  (i_item.cell_layers),
        .i_lon_index    (i_item.lon_index),
        .i_lat_index    (i_item.lat_index),
        .o_in_range     (o_result.in_range),
        .o_layers_out   (o_result.layers_out),
        .o_start_out    (o_result.start_out),
        .o_total_layers (o_result.total_layers),
        .o_peak_layers  (o_result.peak_layers)
    );

endmodule
